[src/kdb_pkg.sv]
// ----------------------------------------------------------------------------
// kdb_pkg
// shared types and constants of the key debounce bank
// ----------------------------------------------------------------------------
package kdb_pkg;

  localparam int unsigned NumKeys   = 7;
  localparam int unsigned TimerW    = 8;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned StatesW   = PhaseW * NumKeys;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [TimerW-1:0]  DebounceReset = TimerW'(10);
  localparam logic [NumKeys-1:0] LevelReset    = NumKeys'(23);
  localparam logic [TimerW-1:0]  TimerMax      = {TimerW{1'b1}};

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] CfgDebounceMs = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgLevelMask  = CfgIndexW'(1);

  typedef enum logic [PhaseW-1:0] {
    PhReleased  = 2'd0,
    PhPressing  = 2'd1,
    PhPressed   = 2'd2,
    PhReleasing = 2'd3
  } key_phase_e;

endpackage

[src/key_debounce_bank_unit.sv]
// ----------------------------------------------------------------------------
// key_debounce_bank_unit
// four-state debouncer for a bank of keys; unless stalled, one poll word per cycle
// ----------------------------------------------------------------------------
// a poll word is held in the input register until its result word can be registered
// throughput: one poll word per cycle unless the output stalls, set by the per-key
//   update between the input register and the result register
// reset: all keys released, timers zero, debounce time 10, level mask 23,
//   both pipeline registers empty
module key_debounce_bank_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [kdb_pkg::NumKeys-1:0]          pin_levels_i,
  input  logic [kdb_pkg::TimerW-1:0]           ms_elapsed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [kdb_pkg::StatesW-1:0]          key_states_o,
  output logic [kdb_pkg::NumKeys-1:0]          press_events_o,
  output logic [kdb_pkg::NumKeys-1:0]          release_events_o,
  input  logic                                 cfg_we_i,
  input  logic [kdb_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [kdb_pkg::CfgDataW-1:0]         cfg_wdata_i
);

  // configuration
  logic [kdb_pkg::TimerW-1:0]  debounce_ms_q;
  logic [kdb_pkg::NumKeys-1:0] level_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= kdb_pkg::DebounceReset;
      level_mask_q  <= kdb_pkg::LevelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kdb_pkg::CfgDebounceMs: debounce_ms_q <= cfg_wdata_i[kdb_pkg::TimerW-1:0];
        kdb_pkg::CfgLevelMask:  level_mask_q  <= cfg_wdata_i[kdb_pkg::NumKeys-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  logic [kdb_pkg::NumKeys-1:0] pins_q;
  logic [kdb_pkg::TimerW-1:0]  ms_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pins_q <= pin_levels_i;
      ms_q   <= ms_elapsed_i;
    end
  end

  // per-key state
  kdb_pkg::key_phase_e         phase_q [kdb_pkg::NumKeys];
  kdb_pkg::key_phase_e         phase_d [kdb_pkg::NumKeys];
  logic [kdb_pkg::TimerW-1:0]  timer_q [kdb_pkg::NumKeys];
  logic [kdb_pkg::TimerW-1:0]  timer_d [kdb_pkg::NumKeys];
  logic [kdb_pkg::NumKeys-1:0] press_d;
  logic [kdb_pkg::NumKeys-1:0] release_d;
  logic [kdb_pkg::StatesW-1:0] states_d;
  logic [kdb_pkg::NumKeys-1:0] down;

  assign down = ~(pins_q ^ level_mask_q);

  always_comb begin
    logic [kdb_pkg::TimerW:0]   sum;
    logic [kdb_pkg::TimerW-1:0] sat;
    press_d   = '0;
    release_d = '0;
    states_d  = '0;
    for (int k = 0; k < kdb_pkg::NumKeys; k++) begin
      phase_d[k] = phase_q[k];
      timer_d[k] = timer_q[k];
      sum = {1'b0, timer_q[k]} + {1'b0, ms_q};
      sat = sum[kdb_pkg::TimerW] ? kdb_pkg::TimerMax : sum[kdb_pkg::TimerW-1:0];
      unique case (phase_q[k])
        kdb_pkg::PhReleased: begin
          if (down[k]) begin
            timer_d[k] = '0;
            phase_d[k] = kdb_pkg::PhPressing;
          end
        end
        kdb_pkg::PhPressed: begin
          if (!down[k]) begin
            timer_d[k] = '0;
            phase_d[k] = kdb_pkg::PhReleasing;
          end
        end
        default: begin
          timer_d[k] = sat;
          if (sat >= debounce_ms_q) begin
            press_d[k]   = (phase_q[k] == kdb_pkg::PhPressing) && down[k];
            release_d[k] = (phase_q[k] == kdb_pkg::PhReleasing) && !down[k];
            phase_d[k]   = down[k] ? kdb_pkg::PhPressed : kdb_pkg::PhReleased;
          end
        end
      endcase
      states_d[kdb_pkg::PhaseW*k +: kdb_pkg::PhaseW] = phase_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < kdb_pkg::NumKeys; k++) begin
        phase_q[k] <= kdb_pkg::PhReleased;
        timer_q[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < kdb_pkg::NumKeys; k++) begin
        phase_q[k] <= phase_d[k];
        timer_q[k] <= timer_d[k];
      end
    end
  end

  // result register
  logic [kdb_pkg::StatesW-1:0] states_q;
  logic [kdb_pkg::NumKeys-1:0] press_q;
  logic [kdb_pkg::NumKeys-1:0] release_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      states_q  <= states_d;
      press_q   <= press_d;
      release_q <= release_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_states_o     = states_q;
  assign press_events_o   = press_q;
  assign release_events_o = release_q;

  // keys shown as pressed or released in the result word
  logic [kdb_pkg::NumKeys-1:0] shown_pressed;
  logic [kdb_pkg::NumKeys-1:0] shown_released;

  always_comb begin
    for (int k = 0; k < kdb_pkg::NumKeys; k++) begin
      shown_pressed[k]  = states_q[kdb_pkg::PhaseW*k +: kdb_pkg::PhaseW] == kdb_pkg::PhPressed;
      shown_released[k] = states_q[kdb_pkg::PhaseW*k +: kdb_pkg::PhaseW] == kdb_pkg::PhReleased;
    end
  end

  a_press_shows_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((press_q & ~shown_pressed) == '0))
    else $error("press event on a key not shown pressed");

  a_release_shows_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((release_q & ~shown_released) == '0))
    else $error("release event on a key not shown released");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(pins_q) && $stable(ms_q)))
    else $error("stalled poll word lost");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result word not registered");

endmodule
